### sv/mhrt_pkg.sv
// ----------------------------------------------------------------------------
// mhrt_pkg
// Shared sizes, function codes and helpers of the min Hamming row tracker.
// ----------------------------------------------------------------------------
package mhrt_pkg;

   localparam int MAX_VARS = 64;
   localparam int MAX_ROWS = 256;

   localparam int VARS_W = 7;
   localparam int ROWS_W = 9;
   localparam int ROW_AW = 8;
   localparam int VAR_AW = 6;
   localparam int DIST_W = 7;
   localparam int CNT_W  = ROW_AW + 1;
   localparam int CSR_AW = 1;
   localparam int CSR_DW = 9;

   localparam logic FUNC_ROW_WRITE = 1'b0;
   localparam logic FUNC_VAR_SET   = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_VARS_IN_USE = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_ROWS_IN_USE = 1'b1;

   localparam logic [VARS_W-1:0] VARS_RESET = VARS_W'(MAX_VARS);
   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(256);

   function automatic logic [MAX_VARS-1:0] column_mask(input logic [VARS_W-1:0] vars);
      logic [MAX_VARS-1:0] m;
      m = '0;
      for (int i = 0; i < MAX_VARS; i++) begin
         m[i] = (VARS_W'(i) < vars);
      end
      return m;
   endfunction

   function automatic logic [DIST_W-1:0] count_ones(input logic [MAX_VARS-1:0] v);
      logic [DIST_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_VARS; i++) begin
         n = n + DIST_W'(v[i]);
      end
      return n;
   endfunction

endpackage

### sv/min_hamming_row_tracker_unit.sv
// ----------------------------------------------------------------------------
// min_hamming_row_tracker_unit
// Row table with per-row Hamming distance to an assignment, and a running
// minimum report after every transaction.
// ----------------------------------------------------------------------------
// Each request first passes a prep state that applies a row write or flips
// the assignment bit. Then one pass runs over the row and distance memories,
// one row per cycle through the single read port, with registered reads, and
// the minimum is gathered; on a variable set that changes the assignment,
// distances are adjusted and written back during the pass. A done state then
// loads the response register. A new request is taken while the previous
// response still waits, and its own response then waits until that one is
// taken. A vars_in_use write holds off requests while every stored distance
// is recomputed.
module min_hamming_row_tracker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [mhrt_pkg::ROW_AW-1:0]         req_row_index,
   input  logic [mhrt_pkg::MAX_VARS-1:0]       req_row_bits,
   input  logic [mhrt_pkg::VAR_AW-1:0]         req_var_index,
   input  logic                                req_var_flag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mhrt_pkg::DIST_W-1:0]         rsp_min_distance,
   output logic [mhrt_pkg::ROWS_W-1:0]         rsp_rows_at_min,
   input  logic                                csr_wr_en,
   input  logic [mhrt_pkg::CSR_AW-1:0]         csr_index,
   input  logic [mhrt_pkg::CSR_DW-1:0]         csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SW_SCAN,
      SW_MODIFY,
      SW_RECALC
   } sweep_type;

   logic [mhrt_pkg::MAX_VARS-1:0] tbl_mem  [mhrt_pkg::MAX_ROWS];
   logic [mhrt_pkg::DIST_W-1:0]   dist_mem [mhrt_pkg::MAX_ROWS];

   state_type                     state_ff;
   sweep_type                     mode_ff;
   logic [mhrt_pkg::MAX_ROWS-1:0] valid_ff;
   logic [mhrt_pkg::MAX_VARS-1:0] assign_ff;
   logic [mhrt_pkg::VARS_W-1:0]   vars_ff;
   logic [mhrt_pkg::ROWS_W-1:0]   rows_ff;
   logic                          recalc_ff;

   logic                          func_ff;
   logic [mhrt_pkg::ROW_AW-1:0]   row_index_ff;
   logic [mhrt_pkg::MAX_VARS-1:0] row_bits_ff;
   logic [mhrt_pkg::VAR_AW-1:0]   var_index_ff;
   logic                          var_flag_ff;

   logic [mhrt_pkg::CNT_W-1:0]    addr_ff;
   logic                          s2_valid_ff;
   logic [mhrt_pkg::ROW_AW-1:0]   s2_addr_ff;
   logic                          s2_live_ff;
   logic [mhrt_pkg::MAX_VARS-1:0] tbl_q_ff;
   logic [mhrt_pkg::DIST_W-1:0]   dist_q_ff;

   logic [mhrt_pkg::DIST_W-1:0]   best_ff;
   logic [mhrt_pkg::CNT_W-1:0]    count_ff;

   logic                          rsp_valid_ff;
   logic [mhrt_pkg::DIST_W-1:0]   rsp_min_ff;
   logic [mhrt_pkg::ROWS_W-1:0]   rsp_cnt_ff;

   logic                          req_accept;
   logic                          recalc_start;
   logic                          recalc_in;
   logic [mhrt_pkg::VARS_W-1:0]   vars_wr;
   logic [mhrt_pkg::MAX_VARS-1:0] col_mask;
   logic [mhrt_pkg::DIST_W-1:0]   row_dist;
   logic                          var_change;
   logic [mhrt_pkg::ROW_AW-1:0]   rd_addr;
   logic                          sweep_issue;
   logic                          sweep_end;
   logic [mhrt_pkg::DIST_W-1:0]   dist_new;
   logic                          s2_row_ok;
   logic                          s2_counted;
   logic                          dist_wb;

   assign req_stall        = (state_ff != ST_IDLE) || recalc_ff;
   assign req_accept       = req_valid && !req_stall;
   assign recalc_start     = (state_ff == ST_IDLE) && recalc_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_min_ff;
   assign rsp_rows_at_min  = rsp_cnt_ff;

   assign col_mask   = mhrt_pkg::column_mask(vars_ff);
   assign row_dist   = mhrt_pkg::count_ones((row_bits_ff ^ assign_ff) & col_mask);
   assign var_change = ({1'b0, var_index_ff} < vars_ff)
                       && (assign_ff[var_index_ff] != var_flag_ff);

   assign rd_addr     = addr_ff[mhrt_pkg::ROW_AW-1:0];
   assign sweep_issue = (state_ff == ST_SWEEP) && (addr_ff < mhrt_pkg::CNT_W'(mhrt_pkg::MAX_ROWS));
   assign sweep_end   = (state_ff == ST_SWEEP) && !sweep_issue && !s2_valid_ff;

   // clamp the column count into 1..MAX_VARS
   always_comb begin
      vars_wr = csr_wdata[mhrt_pkg::VARS_W-1:0];
      if (vars_wr == '0) begin
         vars_wr = mhrt_pkg::VARS_W'(1);
      end else if (vars_wr > mhrt_pkg::VARS_W'(mhrt_pkg::MAX_VARS)) begin
         vars_wr = mhrt_pkg::VARS_W'(mhrt_pkg::MAX_VARS);
      end
   end

   always_comb begin
      recalc_in = recalc_ff;
      if (recalc_start) begin
         recalc_in = 1'b0;
      end
      if (csr_wr_en && (csr_index == mhrt_pkg::CSR_VARS_IN_USE)) begin
         recalc_in = 1'b1;
      end
   end

   always_comb begin
      case (mode_ff)
         SW_MODIFY: begin
            if (tbl_q_ff[var_index_ff] == var_flag_ff) begin
               dist_new = (dist_q_ff != '0) ? dist_q_ff - 1'b1 : dist_q_ff;
            end else begin
               dist_new = (dist_q_ff < vars_ff) ? dist_q_ff + 1'b1 : dist_q_ff;
            end
         end
         SW_RECALC: dist_new = mhrt_pkg::count_ones((tbl_q_ff ^ assign_ff) & col_mask);
         default:   dist_new = dist_q_ff;
      endcase
   end

   assign s2_row_ok  = s2_valid_ff && s2_live_ff;
   assign s2_counted = s2_row_ok && ({1'b0, s2_addr_ff} < rows_ff);
   assign dist_wb    = s2_row_ok && (mode_ff != SW_SCAN);

   // row and distance memories
   always_ff @(posedge clock) begin
      tbl_q_ff  <= tbl_mem[rd_addr];
      dist_q_ff <= dist_mem[rd_addr];
      if ((state_ff == ST_PREP) && (func_ff == mhrt_pkg::FUNC_ROW_WRITE)) begin
         tbl_mem[row_index_ff]  <= row_bits_ff;
         dist_mem[row_index_ff] <= row_dist;
      end else if (dist_wb) begin
         dist_mem[s2_addr_ff] <= dist_new;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff      <= req_func;
         row_index_ff <= req_row_index;
         row_bits_ff  <= req_row_bits;
         var_index_ff <= req_var_index;
         var_flag_ff  <= req_var_flag;
      end
      s2_addr_ff <= rd_addr;
      s2_live_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= SW_SCAN;
         valid_ff     <= '0;
         assign_ff    <= '0;
         vars_ff      <= mhrt_pkg::VARS_RESET;
         rows_ff      <= mhrt_pkg::ROWS_RESET;
         recalc_ff    <= 1'b0;
         addr_ff      <= '0;
         s2_valid_ff  <= 1'b0;
         best_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_min_ff   <= '0;
         rsp_cnt_ff   <= '0;
      end else begin
         recalc_ff <= recalc_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               mhrt_pkg::CSR_VARS_IN_USE: vars_ff <= vars_wr;
               mhrt_pkg::CSR_ROWS_IN_USE: rows_ff <= csr_wdata[mhrt_pkg::ROWS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (state_ff == ST_SWEEP) begin
            s2_valid_ff <= sweep_issue;
            if (sweep_issue) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (s2_counted) begin
               if (dist_new < best_ff) begin
                  best_ff  <= dist_new;
                  count_ff <= mhrt_pkg::CNT_W'(1);
               end else if (dist_new == best_ff) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               addr_ff     <= '0;
               s2_valid_ff <= 1'b0;
               if (recalc_start) begin
                  mode_ff  <= SW_RECALC;
                  state_ff <= ST_SWEEP;
               end else if (req_accept) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               best_ff  <= vars_ff;
               count_ff <= '0;
               if (func_ff == mhrt_pkg::FUNC_ROW_WRITE) begin
                  valid_ff[row_index_ff] <= 1'b1;
                  mode_ff                <= SW_SCAN;
               end else if (var_change) begin
                  assign_ff[var_index_ff] <= var_flag_ff;
                  mode_ff                 <= SW_MODIFY;
               end else begin
                  mode_ff <= SW_SCAN;
               end
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (sweep_end) begin
                  state_ff <= (mode_ff == SW_RECALC) ? ST_IDLE : ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_min_ff   <= best_ff;
                  rsp_cnt_ff   <= count_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### sv/mhrt_checker.sv
// ----------------------------------------------------------------------------
// mhrt_checker
// Port-level checks of the min Hamming row tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mhrt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mhrt_pkg::DIST_W-1:0]       rsp_min_distance,
   input logic [mhrt_pkg::ROWS_W-1:0]       rsp_rows_at_min
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous transaction in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_min_distance)
                                 && $stable(rsp_rows_at_min))
      else $error("stalled response changed");

   a_min_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_distance <= mhrt_pkg::DIST_W'(mhrt_pkg::MAX_VARS))
      else $error("min distance above column count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rows_at_min <= mhrt_pkg::ROWS_W'(mhrt_pkg::MAX_ROWS))
      else $error("row count above table depth");

endmodule

bind min_hamming_row_tracker_unit mhrt_checker u_mhrt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_min_distance (rsp_min_distance),
   .rsp_rows_at_min  (rsp_rows_at_min)
);

### tb/mhrt_checker.sv
// ----------------------------------------------------------------------------
// mhrt_scoreboard
// Watches the request, response and register ports of the min Hamming row
// tracker. Keeps its own row table, per-row distances and assignment, works
// out the minimum report for every accepted request and compares it field by
// field with the responses in order.
// ----------------------------------------------------------------------------
module mhrt_scoreboard
   import mhrt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_func,
   input  logic [ROW_AW-1:0]   req_row_index,
   input  logic [MAX_VARS-1:0] req_row_bits,
   input  logic [VAR_AW-1:0]   req_var_index,
   input  logic                req_var_flag,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [DIST_W-1:0]   rsp_min_distance,
   input  logic [ROWS_W-1:0]   rsp_rows_at_min,
   input  logic                csr_wr_en,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata,
   output int                  failures,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DIST_W-1:0] min_distance;
      logic [ROWS_W-1:0] rows_at_min;
   } nearest_type;

   nearest_type         nearest_fifo[$];
   logic [MAX_VARS-1:0] table_rows [MAX_ROWS];
   bit                  row_live [MAX_ROWS];
   int unsigned         row_dist [MAX_ROWS];
   logic [MAX_VARS-1:0] flags;
   int unsigned         cols;
   int unsigned         row_limit;
   int                  mismatches = 0;

   assign failures = mismatches;

   function automatic int unsigned hamming(input logic [MAX_VARS-1:0] bits);
      logic [MAX_VARS-1:0] keep;
      logic [MAX_VARS-1:0] diff;
      int unsigned n;
      keep = '1;
      if (cols < MAX_VARS) begin
         keep = (MAX_VARS'(1) << cols) - MAX_VARS'(1);
      end
      diff = (bits ^ flags) & keep;
      n = 0;
      for (int i = 0; i < MAX_VARS; i++) begin
         n += diff[i];
      end
      return n;
   endfunction

   function automatic void refresh_distances();
      for (int r = 0; r < MAX_ROWS; r++) begin
         if (row_live[r]) begin
            row_dist[r] = hamming(table_rows[r]);
         end
      end
   endfunction

   function automatic nearest_type nearest_after(input logic                func,
                                                 input logic [ROW_AW-1:0]   ri,
                                                 input logic [MAX_VARS-1:0] rb,
                                                 input logic [VAR_AW-1:0]   vi,
                                                 input logic                vf);
      nearest_type rep;
      int unsigned d;
      int unsigned span;
      int unsigned best;
      int unsigned count;
      if (func == FUNC_ROW_WRITE) begin
         table_rows[ri] = rb;
         row_live[ri] = 1'b1;
         row_dist[ri] = hamming(rb);
      end else if (vi < cols && flags[vi] != vf) begin
         flags[vi] = vf;
         for (int r = 0; r < MAX_ROWS; r++) begin
            if (row_live[r]) begin
               d = row_dist[r];
               if (table_rows[r][vi] == vf) begin
                  if (d > 0) d--;
               end else if (d < cols) begin
                  d++;
               end
               row_dist[r] = d;
            end
         end
      end
      span = (row_limit < MAX_ROWS) ? row_limit : MAX_ROWS;
      best = cols;
      count = 0;
      for (int r = 0; r < span; r++) begin
         if (row_live[r]) begin
            if (row_dist[r] < best) begin
               best = row_dist[r];
               count = 1;
            end else if (row_dist[r] == best) begin
               count++;
            end
         end
      end
      rep.min_distance = DIST_W'(best);
      rep.rows_at_min = ROWS_W'(count);
      return rep;
   endfunction

   always @(posedge clock) begin
      nearest_type want;
      int unsigned v;
      if (reset) begin
         nearest_fifo.delete();
         flags = '0;
         cols = MAX_VARS;
         row_limit = 256;
         foreach (row_live[r]) row_live[r] = 1'b0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (nearest_fifo.size() == 0) begin
               $error("unexpected transaction: min_distance %0d rows_at_min %0d",
                      rsp_min_distance, rsp_rows_at_min);
               mismatches++;
            end else begin
               want = nearest_fifo.pop_front();
               if (rsp_min_distance !== want.min_distance) begin
                  $error("min_distance: expected %0d, actual %0d",
                         want.min_distance, rsp_min_distance);
                  mismatches++;
               end
               if (rsp_rows_at_min !== want.rows_at_min) begin
                  $error("rows_at_min: expected %0d, actual %0d",
                         want.rows_at_min, rsp_rows_at_min);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_VARS_IN_USE) begin
               v = csr_wdata[6:0];
               if (v == 0) v = 1;
               if (v > MAX_VARS) v = MAX_VARS;
               cols = v;
               refresh_distances();
            end else if (csr_index == CSR_ROWS_IN_USE) begin
               row_limit = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            nearest_fifo.push_back(nearest_after(req_func, req_row_index, req_row_bits,
                                                 req_var_index, req_var_flag));
         end
         pending <= nearest_fifo.size();
      end
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the min Hamming row tracker with a directed opening and then phases
// of random row writes and variable sets under changing column and row
// limits, with random idle and stall bursts, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mhrt_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 105;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = FUNC_ROW_WRITE;
   logic [ROW_AW-1:0]   req_row_index = '0;
   logic [MAX_VARS-1:0] req_row_bits = '0;
   logic [VAR_AW-1:0]   req_var_index = '0;
   logic                req_var_flag = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DIST_W-1:0]   rsp_min_distance;
   logic [ROWS_W-1:0]   rsp_rows_at_min;
   logic                csr_wr_en = 1'b0;
   logic [CSR_AW-1:0]   csr_index = CSR_VARS_IN_USE;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   int                  failures;
   int                  pending;
   int unsigned         cycles = 0;
   bit                  calm = 1'b0;
   int unsigned         cols_now = MAX_VARS;
   int unsigned         row_span = 256;
   logic [MAX_VARS-1:0] flags_sent = '0;

   logic [CSR_DW-1:0] col_plan [7] = '{9'd64, 9'd1, 9'd6, 9'd33, 9'd63, 9'd100, 9'h180};
   logic [CSR_DW-1:0] row_plan [7] = '{9'd256, 9'd8, 9'd511, 9'd40, 9'd255, 9'd257, 9'd16};

   always #4 clock = ~clock;

   min_hamming_row_tracker_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_row_index    (req_row_index),
      .req_row_bits     (req_row_bits),
      .req_var_index    (req_var_index),
      .req_var_flag     (req_var_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_min_distance (rsp_min_distance),
      .rsp_rows_at_min  (rsp_rows_at_min),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   mhrt_scoreboard u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_row_index    (req_row_index),
      .req_row_bits     (req_row_bits),
      .req_var_index    (req_var_index),
      .req_var_flag     (req_var_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_min_distance (rsp_min_distance),
      .rsp_rows_at_min  (rsp_rows_at_min),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** min_hamming_row_tracker_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
         end
         repeat ($urandom_range(0, 11)) @(posedge clock);
      end
   end

   task automatic send_request(input logic                func,
                               input logic [ROW_AW-1:0]   ri,
                               input logic [MAX_VARS-1:0] rb,
                               input logic [VAR_AW-1:0]   vi,
                               input logic                vf);
      req_valid     <= 1'b1;
      req_func      <= func;
      req_row_index <= ri;
      req_row_bits  <= rb;
      req_var_index <= vi;
      req_var_flag  <= vf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic put_row(input logic [ROW_AW-1:0] ri, input logic [MAX_VARS-1:0] rb);
      send_request(FUNC_ROW_WRITE, ri, rb, VAR_AW'($urandom), 1'($urandom));
   endtask

   task automatic put_var(input logic [VAR_AW-1:0] vi, input logic vf);
      if (vi < cols_now) flags_sent[vi] = vf;
      send_request(FUNC_VAR_SET, ROW_AW'($urandom), {$urandom, $urandom}, vi, vf);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_columns(input logic [CSR_DW-1:0] raw);
      int unsigned v;
      v = raw[6:0];
      if (v == 0) v = 1;
      if (v > MAX_VARS) v = MAX_VARS;
      cols_now = v;
      write_csr(CSR_VARS_IN_USE, raw);
   endtask

   task automatic set_row_limit(input logic [CSR_DW-1:0] raw);
      row_span = raw;
      write_csr(CSR_ROWS_IN_USE, raw);
   endtask

   initial begin
      logic [CSR_DW-1:0]   vraw;
      logic [CSR_DW-1:0]   rraw;
      logic [MAX_VARS-1:0] keep;
      logic [MAX_VARS-1:0] rb;
      logic [ROW_AW-1:0]   ri;
      logic [VAR_AW-1:0]   vi;
      logic                vf;
      int unsigned         span_hi;
      int unsigned         done_items;
      int unsigned         pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_var(6'd5, 1'b0);
      put_row(8'd0, '0);
      put_row(8'd255, '1);
      put_row(8'd128, 64'h8000_0000_0000_0001);
      put_var(6'd0, 1'b1);
      put_var(6'd63, 1'b1);
      put_var(6'd63, 1'b1);
      put_row(8'd0, '1);
      put_row(8'd17, 64'hAAAA_AAAA_AAAA_AAAA);
      put_row(8'd18, 64'h5555_5555_5555_5555);
      put_var(6'd0, 1'b0);
      put_row(8'd1, '0);
      wait_idle();
      set_row_limit(9'd0);
      put_var(6'd1, 1'b1);
      wait_idle();
      set_row_limit(9'h1FF);
      set_columns(9'd0);
      put_var(6'd1, 1'b0);
      put_var(6'd0, 1'b1);
      put_row(8'd2, 64'hFFFF_FFFF_FFFF_FFFE);
      wait_idle();
      set_row_limit(9'd2);
      set_columns(9'h17F);
      put_var(6'd63, 1'b0);
      put_row(8'd200, '0);
      put_var(6'd10, 1'b1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase == PHASES - 1);
         vraw = (phase < 7) ? col_plan[phase] : CSR_DW'($urandom_range(0, 511));
         rraw = (phase < 7) ? row_plan[phase] : CSR_DW'($urandom_range(0, 511));
         set_row_limit(rraw);
         set_columns(vraw);
         keep = '1;
         if (cols_now < MAX_VARS) keep = (MAX_VARS'(1) << cols_now) - MAX_VARS'(1);
         span_hi = (row_span == 0 || row_span >= MAX_ROWS) ? MAX_ROWS - 1 : row_span - 1;
         done_items = 0;
         while (done_items < PHASE_ITEMS) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 45) begin
               ri = ($urandom_range(0, 9) < 7) ? ROW_AW'($urandom_range(0, span_hi))
                                               : ROW_AW'($urandom_range(0, MAX_ROWS - 1));
               pick = $urandom_range(0, 3);
               if (pick == 0) begin
                  rb = {$urandom, $urandom};
               end else if (pick == 3) begin
                  rb = $urandom_range(0, 1) ? '1 : '0;
               end else begin
                  rb = flags_sent;
                  repeat ($urandom_range(0, 3)) rb[$urandom_range(0, cols_now - 1)] ^= 1'b1;
                  rb = (rb & keep) | ({$urandom, $urandom} & ~keep);
               end
               done_items++;
               put_row(ri, rb);
            end else begin
               vi = ($urandom_range(0, 9) != 0) ? VAR_AW'($urandom_range(0, cols_now - 1))
                                                : VAR_AW'($urandom_range(0, MAX_VARS - 1));
               vf = ($urandom_range(0, 9) < 7) ? ~flags_sent[vi] : 1'($urandom);
               done_items++;
               put_var(vi, vf);
            end
         end
         wait_idle();
      end

      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("** min_hamming_row_tracker_unit: PASSED **");
      end else begin
         $display("** min_hamming_row_tracker_unit: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
sv/mhrt_pkg.sv
sv/min_hamming_row_tracker_unit.sv
sv/mhrt_checker.sv
tb/mhrt_checker.sv
tb/tb_top.sv
